// ===== src/pipeline_command_tokenizer_core_assert.svh =====
// Assertion macros for the pipeline command tokenizer RTL.
`ifndef PIPELINE_COMMAND_TOKENIZER_CORE_ASSERT_SVH
`define PIPELINE_COMMAND_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PCTOK_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pctok: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define PCTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pctok: next-cycle check failed");

`endif

// ===== src/pctok_pkg.sv =====
// Shared types and constants of the pipeline command tokenizer.
`timescale 1ns / 1ps

package pctok_pkg;

    // Status codes reported on the last byte of a line.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_MANY = 2'd1;
    localparam logic [1:0] ST_TOO_BIG  = 2'd2;

    // Byte classes assigned by the front end.
    localparam logic [1:0] KIND_END   = 2'd0;
    localparam logic [1:0] KIND_PIPE  = 2'd1;
    localparam logic [1:0] KIND_SPACE = 2'd2;
    localparam logic [1:0] KIND_WORD  = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PIPE  = 8'h7C;

    // A classified byte as it travels through the queue.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } token_t;

endpackage

// ===== src/pctok_if.sv =====
// Channel interfaces of the pipeline command tokenizer.
`timescale 1ns / 1ps

// Line byte channel.
interface pctok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, ch, last, input ready);
    modport sink (input valid, ch, last, output ready);
endinterface

// Per-byte result channel.
interface pctok_out_if;
    logic       valid;
    logic       ready;
    logic       write_valid;
    logic [2:0] cmd_index;
    logic       in_args;
    logic [7:0] position;
    logic [7:0] char_out;
    logic       sep_before;
    logic       done_res;
    logic [1:0] status;
    logic [3:0] cmd_total;

    modport source (output valid, write_valid, cmd_index, in_args, position, char_out,
                    sep_before, done_res, status, cmd_total, input ready);
    modport sink (input valid, write_valid, cmd_index, in_args, position, char_out,
                  sep_before, done_res, status, cmd_total, output ready);
endinterface

// ===== src/pipeline_command_tokenizer_core.sv =====
// Top level of the pipeline command tokenizer.
`timescale 1ns / 1ps
//
// Channel   Direction  Payload                                    Transfer
// cmd_in    in         ch[7:0], last                              valid && ready
// res_out   out        write_valid, cmd_index, in_args, position, valid && ready
//                      char_out, sep_before, done_res, status,
//                      cmd_total
//
// One byte per cycle sustained while res_out is not stalled; a byte's result passes
// through the queue stage, then the result register, before it can transfer.
// The two-entry queue lets the front keep taking bytes while a result waits.
// A stalled res_out holds the result; bytes stop once the queue fills.
// rst_n clears all tokenizer state; state also returns to reset after each last byte.

`include "pipeline_command_tokenizer_core_assert.svh"

module pipeline_command_tokenizer_core #(
    parameter int MAX_COMMANDS = 8,
    parameter int NAME_LIMIT   = 64,
    parameter int ARGS_LIMIT   = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    pctok_in_if.sink     cmd_in,
    pctok_out_if.source  res_out
);

    pctok_pkg::token_t front_tok;
    pctok_pkg::token_t q_tok;
    logic              push_valid;
    logic              push_ready;
    logic              q_valid;
    logic              q_ready;

    // Classification of incoming bytes.
    pctok_front u_front (
        .cmd_in     (cmd_in),
        .tok        (front_tok),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // Decoupling queue.
    pctok_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tok   (front_tok),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_tok    (q_tok)
    );

    // Tokenizer state and result register.
    pctok_back #(
        .MAX_COMMANDS (MAX_COMMANDS),
        .NAME_LIMIT   (NAME_LIMIT),
        .ARGS_LIMIT   (ARGS_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (q_valid),
        .tok_ready (q_ready),
        .tok       (q_tok),
        .res_out   (res_out)
    );

    // Status and count are only reported on the last byte of a line.
    `PCTOK_ASSERT_IMPLY(a_summary_on_last, clk, rst_n,
        res_out.valid && !res_out.done_res,
        res_out.status == pctok_pkg::ST_OK && res_out.cmd_total == 4'd0)
    // A separator space is only ever requested inside an argument string.
    `PCTOK_ASSERT_IMPLY(a_sep_in_args, clk, rst_n,
        res_out.valid && res_out.sep_before,
        res_out.write_valid && res_out.in_args)
    // Every token taken from the queue shows up as a result in the next cycle.
    `PCTOK_ASSERT_NEXT(a_pop_gives_result, clk, rst_n, q_valid && q_ready, res_out.valid)

endmodule

// ===== src/pctok_front.sv =====
// Front end: accepts line bytes and classifies them into tokens.
`timescale 1ns / 1ps

module pctok_front (
    pctok_in_if.sink          cmd_in,
    output pctok_pkg::token_t tok,
    output logic              push_valid,
    input  logic              push_ready
);

    // Byte classification: terminator, pipe, space or word character.
    always_comb
    begin
        tok.ch   = cmd_in.ch;
        tok.last = cmd_in.last;
        if (cmd_in.ch == 8'h00)
        begin
            tok.kind = pctok_pkg::KIND_END;
        end
        else if (cmd_in.ch == pctok_pkg::CH_PIPE)
        begin
            tok.kind = pctok_pkg::KIND_PIPE;
        end
        else if (cmd_in.ch == pctok_pkg::CH_SPACE)
        begin
            tok.kind = pctok_pkg::KIND_SPACE;
        end
        else
        begin
            tok.kind = pctok_pkg::KIND_WORD;
        end
    end

    // A transfer on the input channel pushes one token.
    assign push_valid   = cmd_in.valid;
    assign cmd_in.ready = push_ready;

endmodule

// ===== src/pctok_queue.sv =====
// Two-entry token queue between the front end and the back end.
`timescale 1ns / 1ps

module pctok_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  pctok_pkg::token_t push_tok,
    output logic              pop_valid,
    input  logic              pop_ready,
    output pctok_pkg::token_t pop_tok
);

    pctok_pkg::token_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_tok    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill-level update.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// ===== src/pctok_back.sv =====
// Back end: tokenizer state, command bookkeeping and the result register.
`timescale 1ns / 1ps

module pctok_back #(
    parameter int MAX_COMMANDS = 8,
    parameter int NAME_LIMIT   = 64,
    parameter int ARGS_LIMIT   = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    output logic              tok_ready,
    input  pctok_pkg::token_t tok,
    pctok_out_if.source       res_out
);

    localparam int CW  = $clog2(MAX_COMMANDS + 1);
    localparam int NLW = $clog2(NAME_LIMIT);
    localparam int AW  = $clog2(ARGS_LIMIT);
    localparam int XW  = (AW + 2 > 9) ? AW + 2 : 9;
    localparam logic [CW-1:0]  MAX_CMD  = CW'(MAX_COMMANDS);
    localparam logic [NLW-1:0] NAME_MAX = NLW'(NAME_LIMIT - 1);
    localparam logic [XW-1:0]  ARGS_LIM = XW'(ARGS_LIMIT);

    // Tokenizer state.
    logic [1:0]     err_reg, err_next;
    logic [CW-1:0]  seen_reg, seen_next;
    logic           committed_reg, committed_next;
    logic           at_start_reg, at_start_next;
    logic           inside_reg, inside_next;
    logic           name_fin_reg, name_fin_next;
    logic [NLW-1:0] name_len_reg, name_len_next;
    logic [AW-1:0]  args_len_reg, args_len_next;
    logic           has_space_reg, has_space_next;
    logic           first_arg_reg, first_arg_next;
    logic           ended_reg, ended_next;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic       wv_reg;
    logic [2:0] idx_reg;
    logic       args_sel_reg;
    logic [7:0] pos_reg;
    logic [7:0] char_reg;
    logic       sep_reg;
    logic       done_reg;
    logic [1:0] status_reg;
    logic [3:0] count_reg;

    // Per-byte working values.
    logic          pop;
    logic          starting;
    logic          first_arg;
    logic [XW-1:0] args_p;
    logic [XW-1:0] args_need;
    logic [XW-1:0] name_ext;
    logic [CW-1:0] seen_idx;
    logic [CW+2:0] idx_ext;
    logic [CW+3:0] cnt_ext;
    logic          w_valid;
    logic          w_args;
    logic [7:0]    w_pos;
    logic          w_sep;
    logic [1:0]    r_status;
    logic [3:0]    r_count;

    assign pop       = tok_valid && (!out_valid_reg || res_out.ready);
    assign tok_ready = !out_valid_reg || res_out.ready;

    // Argument placement: a new word after the first one leaves room for a space.
    assign starting  = !inside_reg;
    assign first_arg = starting ? (args_len_reg == '0) : first_arg_reg;
    assign args_p    = XW'(args_len_reg) + XW'(starting && !first_arg);
    assign args_need = args_p + XW'(1) + XW'(first_arg);
    assign name_ext  = XW'(name_len_reg);
    assign seen_idx  = committed_reg ? seen_reg - CW'(1) : seen_reg;
    assign idx_ext   = (CW + 3)'(seen_idx);

    // Next-state logic for one token.
    always_comb
    begin
        err_next       = err_reg;
        seen_next      = seen_reg;
        committed_next = committed_reg;
        at_start_next  = at_start_reg;
        inside_next    = inside_reg;
        name_fin_next  = name_fin_reg;
        name_len_next  = name_len_reg;
        args_len_next  = args_len_reg;
        has_space_next = has_space_reg;
        first_arg_next = first_arg_reg;
        ended_next     = ended_reg;
        w_valid        = 1'b0;
        w_args         = 1'b0;
        w_pos          = 8'd0;
        w_sep          = 1'b0;
        if (err_reg == pctok_pkg::ST_OK && !ended_reg)
        begin
            case (tok.kind)
                pctok_pkg::KIND_END:
                begin
                    ended_next = 1'b1;
                end
                pctok_pkg::KIND_PIPE:
                begin
                    // A space-only segment between two pipes is an empty command.
                    if (!committed_reg && has_space_reg && !at_start_reg)
                    begin
                        if (seen_reg >= MAX_CMD)
                        begin
                            err_next = pctok_pkg::ST_TOO_MANY;
                        end
                        else
                        begin
                            seen_next = seen_reg + CW'(1);
                        end
                    end
                    committed_next = 1'b0;
                    has_space_next = 1'b0;
                    inside_next    = 1'b0;
                    name_fin_next  = 1'b0;
                    name_len_next  = '0;
                    args_len_next  = '0;
                    first_arg_next = 1'b0;
                    at_start_next  = 1'b0;
                end
                pctok_pkg::KIND_SPACE:
                begin
                    has_space_next = 1'b1;
                    if (inside_reg)
                    begin
                        inside_next   = 1'b0;
                        name_fin_next = 1'b1;
                    end
                end
                default:
                begin
                    // Word byte: the segment becomes a command at its first word byte.
                    if (!committed_reg && seen_reg >= MAX_CMD)
                    begin
                        err_next = pctok_pkg::ST_TOO_MANY;
                    end
                    else
                    begin
                        if (!committed_reg)
                        begin
                            seen_next      = seen_reg + CW'(1);
                            committed_next = 1'b1;
                        end
                        if (!name_fin_reg)
                        begin
                            if (name_len_reg >= NAME_MAX)
                            begin
                                err_next = pctok_pkg::ST_TOO_BIG;
                            end
                            else
                            begin
                                w_valid       = 1'b1;
                                w_pos         = name_ext[7:0];
                                name_len_next = name_len_reg + NLW'(1);
                                inside_next   = 1'b1;
                            end
                        end
                        else
                        begin
                            if (args_need >= ARGS_LIM)
                            begin
                                err_next = pctok_pkg::ST_TOO_BIG;
                            end
                            else
                            begin
                                w_valid        = 1'b1;
                                w_args         = 1'b1;
                                w_pos          = args_p[7:0];
                                w_sep          = starting && !first_arg;
                                first_arg_next = first_arg;
                                args_len_next  = args_p[AW-1:0] + AW'(1);
                                inside_next    = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end

        // Line summary, then return to the reset state after the last byte.
        cnt_ext  = (CW + 4)'(seen_next);
        r_status = tok.last ? err_next : pctok_pkg::ST_OK;
        r_count  = 4'd0;
        if (tok.last && err_next == pctok_pkg::ST_OK)
        begin
            r_count = cnt_ext[3:0];
        end
        if (tok.last)
        begin
            err_next       = pctok_pkg::ST_OK;
            seen_next      = '0;
            committed_next = 1'b0;
            at_start_next  = 1'b1;
            inside_next    = 1'b0;
            name_fin_next  = 1'b0;
            name_len_next  = '0;
            args_len_next  = '0;
            has_space_next = 1'b0;
            first_arg_next = 1'b0;
            ended_next     = 1'b0;
        end
    end

    assign out_valid_next = pop ? 1'b1 : (res_out.ready ? 1'b0 : out_valid_reg);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg       <= pctok_pkg::ST_OK;
            seen_reg      <= '0;
            committed_reg <= 1'b0;
            at_start_reg  <= 1'b1;
            inside_reg    <= 1'b0;
            name_fin_reg  <= 1'b0;
            name_len_reg  <= '0;
            args_len_reg  <= '0;
            has_space_reg <= 1'b0;
            first_arg_reg <= 1'b0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                err_reg       <= err_next;
                seen_reg      <= seen_next;
                committed_reg <= committed_next;
                at_start_reg  <= at_start_next;
                inside_reg    <= inside_next;
                name_fin_reg  <= name_fin_next;
                name_len_reg  <= name_len_next;
                args_len_reg  <= args_len_next;
                has_space_reg <= has_space_next;
                first_arg_reg <= first_arg_next;
                ended_reg     <= ended_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            wv_reg       <= w_valid;
            idx_reg      <= w_valid ? idx_ext[2:0] : 3'd0;
            args_sel_reg <= w_args;
            pos_reg      <= w_pos;
            char_reg     <= w_valid ? tok.ch : 8'd0;
            sep_reg      <= w_sep;
            done_reg     <= tok.last;
            status_reg   <= r_status;
            count_reg    <= r_count;
        end
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.write_valid = wv_reg;
    assign res_out.cmd_index   = idx_reg;
    assign res_out.in_args     = args_sel_reg;
    assign res_out.position    = pos_reg;
    assign res_out.char_out    = char_reg;
    assign res_out.sep_before  = sep_reg;
    assign res_out.done_res    = done_reg;
    assign res_out.status      = status_reg;
    assign res_out.cmd_total   = count_reg;

endmodule

// ===== verif/tb_pipeline_command_tokenizer_core.sv =====
// Self-checking testbench for the pipeline command tokenizer core.
`timescale 1ns / 1ps

// One result transfer of the tokenizer, field by field.
typedef struct packed {
    logic       write_valid;
    logic [2:0] cmd_index;
    logic       in_args;
    logic [7:0] position;
    logic [7:0] char_out;
    logic       sep_before;
    logic       done_res;
    logic [1:0] status;
    logic [3:0] cmd_total;
} tok_result_t;

// Tracks the line state of the tokenizer and checks each result against it.
class tokenizer_scoreboard;
    localparam int MAX_CMDS  = 8;
    localparam int NAME_MAX  = 64;
    localparam int ARGS_MAX  = 256;
    localparam logic [7:0] CH_NUL = 8'h00;

    tok_result_t expected_results[$];
    int          errors;

    // Line and segment state.
    logic [1:0] err;
    logic [3:0] commands_seen;
    bit         seg_committed;
    bit         seg_at_start;
    bit         seg_has_space;
    bit         in_word;
    bit         name_done;
    bit         first_arg;
    bit         line_ended;
    logic [6:0] name_len;
    logic [8:0] args_len;

    function new();
        errors = 0;
        reset_line();
    endfunction

    function void clear_segment();
        seg_committed = 0;
        seg_has_space = 0;
        in_word       = 0;
        name_done     = 0;
        name_len      = '0;
        args_len      = '0;
        first_arg     = 0;
    endfunction

    function void reset_line();
        err           = pctok_pkg::ST_OK;
        commands_seen = '0;
        seg_at_start  = 1;
        line_ended    = 0;
        clear_segment();
    endfunction

    // Opens a new command slot for the current segment, or flags overflow.
    function bit open_command();
        if (commands_seen >= MAX_CMDS)
        begin
            err = pctok_pkg::ST_TOO_MANY;
            return 0;
        end
        commands_seen = commands_seen + 4'd1;
        seg_committed = 1;
        return 1;
    endfunction

    function tok_result_t predict_byte_result(logic [7:0] ch, logic last);
        tok_result_t r;
        bit          granted;
        bit          starting;
        bit          opens_list;
        int          p;
        int          need;
        r = '0;
        if (err == pctok_pkg::ST_OK && !line_ended)
        begin
            if (ch == CH_NUL)
            begin
                line_ended = 1;
            end
            else if (ch == pctok_pkg::CH_PIPE)
            begin
                // A spaces-only segment counts only when it sits between two pipes.
                if (!seg_committed && seg_has_space && !seg_at_start)
                    void'(open_command());
                clear_segment();
                seg_at_start = 0;
            end
            else if (ch == pctok_pkg::CH_SPACE)
            begin
                seg_has_space = 1;
                if (in_word)
                begin
                    in_word   = 0;
                    name_done = 1;
                end
            end
            else
            begin
                granted = seg_committed ? 1'b1 : open_command();
                if (granted)
                begin
                    if (!name_done)
                    begin
                        p = name_len;
                        if (p + 1 >= NAME_MAX)
                        begin
                            err = pctok_pkg::ST_TOO_BIG;
                        end
                        else
                        begin
                            r.write_valid = 1;
                            r.position    = p[7:0];
                            r.char_out    = ch;
                            name_len      = 7'(p + 1);
                            in_word       = 1;
                        end
                    end
                    else
                    begin
                        // Argument words are joined with a single space.
                        starting   = !in_word;
                        opens_list = starting ? (args_len == 0) : first_arg;
                        if (opens_list)
                        begin
                            p    = args_len;
                            need = p + 2;
                        end
                        else
                        begin
                            p    = starting ? args_len + 1 : args_len;
                            need = p + 1;
                        end
                        if (need >= ARGS_MAX)
                        begin
                            err = pctok_pkg::ST_TOO_BIG;
                        end
                        else
                        begin
                            r.write_valid = 1;
                            r.in_args     = 1;
                            r.position    = p[7:0];
                            r.char_out    = ch;
                            r.sep_before  = starting && !opens_list;
                            first_arg     = opens_list;
                            args_len      = 9'(p + 1);
                            in_word       = 1;
                        end
                    end
                    if (r.write_valid)
                        r.cmd_index = 3'(commands_seen - 4'd1);
                end
            end
        end
        r.done_res = last;
        if (last)
        begin
            r.status    = err;
            r.cmd_total = (err == pctok_pkg::ST_OK) ? commands_seen : 4'd0;
            reset_line();
        end
        return r;
    endfunction

    // Called for every accepted input byte.
    function void note_byte(logic [7:0] ch, logic last);
        expected_results.push_back(predict_byte_result(ch, last));
    endfunction

    function void check_field(string fname, logic [7:0] expv, logic [7:0] actv);
        if (actv !== expv)
        begin
            $error("%s mismatch: expected %0h, actual %0h", fname, expv, actv);
            errors++;
        end
    endfunction

    // Called for every accepted result.
    function void check_result(tok_result_t got);
        tok_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result transfer with no byte outstanding");
            errors++;
            return;
        end
        want = expected_results.pop_front();
        check_field("write_valid", 8'(want.write_valid), 8'(got.write_valid));
        check_field("cmd_index", 8'(want.cmd_index), 8'(got.cmd_index));
        check_field("in_args", 8'(want.in_args), 8'(got.in_args));
        check_field("position", want.position, got.position);
        check_field("char_out", want.char_out, got.char_out);
        check_field("sep_before", 8'(want.sep_before), 8'(got.sep_before));
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("status", 8'(want.status), 8'(got.status));
        check_field("cmd_total", 8'(want.cmd_total), 8'(got.cmd_total));
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module tb_pipeline_command_tokenizer_core;

    localparam int MAX_COMMANDS = 8;
    localparam int NAME_LIMIT   = 64;
    localparam int ARGS_LIMIT   = 256;
    localparam int ITEM_TARGET  = 2000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [7:0] CH_NUL = 8'h00;

    // Kinds of generated lines.
    typedef enum int {
        LINE_PLAIN,
        LINE_TOO_MANY,
        LINE_LONG_NAME,
        LINE_LONG_ARGS,
        LINE_NOISE
    } line_kind_t;

    logic        clk;
    logic        rst_n;
    int unsigned cycle_cnt;
    int unsigned bytes_sent;

    tokenizer_scoreboard sb;

    pctok_in_if  in_if ();
    pctok_out_if out_if ();

    pipeline_command_tokenizer_core #(
        .MAX_COMMANDS (MAX_COMMANDS),
        .NAME_LIMIT   (NAME_LIMIT),
        .ARGS_LIMIT   (ARGS_LIMIT)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (in_if.sink),
        .res_out (out_if.source)
    );

    // Clock.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Idles about a quarter of the time, except in a recurring quiet window.
    function automatic bit take_break();
        int unsigned phase;
        phase = cycle_cnt % 5000;
        if (phase >= 2000 && phase < 3000)
            return 0;
        return $urandom_range(0, 99) < 25;
    endfunction

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure and a check on every transfer.
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_result('{
                write_valid: out_if.write_valid,
                cmd_index:   out_if.cmd_index,
                in_args:     out_if.in_args,
                position:    out_if.position,
                char_out:    out_if.char_out,
                sep_before:  out_if.sep_before,
                done_res:    out_if.done_res,
                status:      out_if.status,
                cmd_total:   out_if.cmd_total
            });
        out_if.ready <= !take_break();
    end

    // Sends one byte and waits for its transfer.
    task automatic send_byte(input logic [7:0] ch, input logic last);
        while (take_break())
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.ch    <= ch;
        in_if.last  <= last;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        sb.note_byte(ch, last);
        bytes_sent++;
    endtask

    task automatic send_line(input logic [7:0] line[$]);
        foreach (line[i])
            send_byte(line[i], i == line.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] line[$];
        for (int i = 0; i < s.len(); i++)
            line.push_back(s[i]);
        send_line(line);
    endtask

    // Appends a word of random non-separator bytes.
    function automatic void add_word(ref logic [7:0] line[$], input int len);
        logic [7:0] c;
        repeat (len)
        begin
            do
                c = 8'($urandom_range(1, 255));
            while (c == pctok_pkg::CH_SPACE || c == pctok_pkg::CH_PIPE);
            line.push_back(c);
        end
    endfunction

    function automatic void add_spaces(ref logic [7:0] line[$], input int n);
        repeat (n)
            line.push_back(pctok_pkg::CH_SPACE);
    endfunction

    // Builds one command line of the given kind.
    function automatic void build_line(ref logic [7:0] line[$], input line_kind_t kind);
        int nseg;
        int name_n;
        int arg_target;
        int arg_total;
        int wlen;
        line.delete();
        if (kind == LINE_NOISE)
        begin
            repeat ($urandom_range(1, 12))
            begin
                case ($urandom_range(0, 5))
                    0: line.push_back(pctok_pkg::CH_SPACE);
                    1: line.push_back(pctok_pkg::CH_PIPE);
                    2: line.push_back(CH_NUL);
                    default: line.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        nseg = (kind == LINE_TOO_MANY) ? $urandom_range(8, 11) : $urandom_range(1, 4);
        for (int s = 0; s < nseg; s++)
        begin
            if (s > 0)
                line.push_back(pctok_pkg::CH_PIPE);
            add_spaces(line, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            if (s == 0 && kind == LINE_LONG_NAME)
            begin
                add_word(line, $urandom_range(NAME_LIMIT - 3, NAME_LIMIT + 2));
            end
            else if (s == 0 && kind == LINE_LONG_ARGS)
            begin
                // Fill the argument string up to around its limit.
                add_word(line, $urandom_range(1, 4));
                arg_target = $urandom_range(ARGS_LIMIT - 8, ARGS_LIMIT + 4);
                arg_total  = 0;
                while (arg_total < arg_target)
                begin
                    wlen = $urandom_range(8, 40);
                    if (wlen > arg_target - arg_total)
                        wlen = arg_target - arg_total;
                    add_spaces(line, 1);
                    add_word(line, wlen);
                    arg_total += wlen + 1;
                end
            end
            else
            begin
                case ($urandom_range(0, 11))
                    0: ;
                    1: add_spaces(line, $urandom_range(1, 3));
                    default:
                    begin
                        name_n = $urandom_range(1, 6);
                        add_word(line, name_n);
                        repeat ($urandom_range(0, 3))
                        begin
                            add_spaces(line, ($urandom_range(0, 4) == 0) ? 2 : 1);
                            add_word(line, $urandom_range(1, 6));
                        end
                    end
                endcase
            end
            add_spaces(line, ($urandom_range(0, 3) == 0) ? 1 : 0);
        end
        // Sometimes a zero byte ends the text early, with trailing bytes ignored.
        if ($urandom_range(0, 7) == 0)
        begin
            line.push_back(CH_NUL);
            repeat ($urandom_range(0, 3))
                line.push_back(8'($urandom_range(0, 255)));
        end
        if (line.size() == 0)
            line.push_back(CH_NUL);
    endfunction

    // Reset, directed lines, then random lines, then drain.
    initial
    begin
        logic [7:0] line[$];
        line_kind_t kind;
        int         pick;
        int         n_lines;
        sb           = new();
        cycle_cnt    = 0;
        bytes_sent   = 0;
        rst_n        = 1'b0;
        in_if.valid  = 1'b0;
        in_if.ch     = '0;
        in_if.last   = 1'b0;
        out_if.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty line made of the terminator alone.
        line = '{CH_NUL};
        send_line(line);
        // Name with arguments, double space, empty segment, spaces between pipes.
        send_text("ls -l  x|| |wc ");
        // Leading and trailing spaces-only segments, bytes with the top bit set.
        line = '{pctok_pkg::CH_SPACE, pctok_pkg::CH_PIPE, 8'hFF, 8'h80,
                 pctok_pkg::CH_SPACE, 8'h01, pctok_pkg::CH_PIPE, pctok_pkg::CH_SPACE};
        send_line(line);
        // Zero byte in the middle of the line.
        line = '{8'h61, CH_NUL, 8'h62, pctok_pkg::CH_PIPE};
        send_line(line);

        // Random lines, the first few forced onto the error paths.
        n_lines = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (n_lines == 0 || pick < 8)
                kind = LINE_TOO_MANY;
            else if (n_lines == 1 || pick < 12)
                kind = LINE_LONG_NAME;
            else if (n_lines == 2 || pick < 16)
                kind = LINE_LONG_ARGS;
            else if (pick < 30)
                kind = LINE_NOISE;
            else
                kind = LINE_PLAIN;
            build_line(line, kind);
            send_line(line);
            n_lines++;
        end
        in_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
